/* src/scm_pkg.sv */
// Shared types and constants for the stack calculator.
`timescale 1ns / 1ps
package scm_pkg;
   localparam int unsigned ValueWidth = 31;
   localparam int unsigned KindWidth = 4;
   localparam logic signed [31:0] MagLimit = 32'sd1000000000;

   typedef enum logic [KindWidth-1:0] {
      KIND_START  = 4'd0,
      KIND_PUSH   = 4'd1,
      KIND_POP    = 4'd2,
      KIND_NEGATE = 4'd3,
      KIND_DUP    = 4'd4,
      KIND_SWAP   = 4'd5,
      KIND_ADD    = 4'd6,
      KIND_SUB    = 4'd7,
      KIND_MUL    = 4'd8,
      KIND_DIV    = 4'd9,
      KIND_MOD    = 4'd10,
      KIND_FINISH = 4'd11
   } kind_type;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4,
      OP_NEG = 3'd5
   } alu_op_type;

   // Handshake between the sequencer and the arithmetic unit.
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef struct packed {
      logic done;
      logic error;
   } alu_status_type;
endpackage

/* src/scm_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module scm_ram #(
   parameter int unsigned WIDTH = 31,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* src/scm_alu.sv */
// Shared arithmetic unit: add, subtract, negate and multiply,
// bit-serial restoring division for quotient and remainder.
`timescale 1ns / 1ps
module scm_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  scm_pkg::alu_ctrl_type         ctrl,
   input  logic signed [scm_pkg::ValueWidth-1:0] below,
   input  logic signed [scm_pkg::ValueWidth-1:0] top,
   output scm_pkg::alu_status_type       status,
   output logic signed [scm_pkg::ValueWidth-1:0] result
);
   localparam int unsigned W = scm_pkg::ValueWidth;

   typedef enum logic [1:0] {S_IDLE, S_MULT, S_DIV, S_DONE} state_type;

   state_type state_ff, state_in;
   scm_pkg::alu_op_type op_ff, op_in;
   logic [4:0] count_ff, count_in;
   logic [W-1:0] quot_ff, quot_in;      // dividend shifting into quotient
   logic [W:0]   rem_ff, rem_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic signed [2*W-1:0] prod_ff, prod_in;
   logic signed [2*W-1:0] wide_ff, wide_in;
   logic err_ff, err_in, done_ff, done_in;

   logic signed [2*W-1:0] sum_w;
   logic [W:0] trial;
   logic [W-1:0] abs_b, abs_t;

   always_comb begin
      abs_b = below[W-1] ? W'(-below) : W'(below);
      abs_t = top[W-1] ? W'(-top) : W'(top);
      state_in = state_ff;
      op_in = op_ff;
      count_in = count_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      prod_in = prod_ff;
      wide_in = wide_ff;
      err_in = err_ff;
      done_in = 1'b0;
      sum_w = '0;
      trial = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               op_in = ctrl.op;
               case (ctrl.op)
                  scm_pkg::OP_ADD: sum_w = (2*W)'(below) + (2*W)'(top);
                  scm_pkg::OP_SUB: sum_w = (2*W)'(below) - (2*W)'(top);
                  scm_pkg::OP_NEG: sum_w = -(2*W)'(top);
                  default: sum_w = '0;
               endcase
               wide_in = sum_w;
               if (ctrl.op == scm_pkg::OP_MUL) begin
                  prod_in = (2*W)'(below) * (2*W)'(top);
                  state_in = S_MULT;
               end else if (ctrl.op == scm_pkg::OP_DIV || ctrl.op == scm_pkg::OP_MOD) begin
                  quot_in = abs_b;
                  rem_in = '0;
                  dvs_in = abs_t;
                  neg_q_in = below[W-1] ^ top[W-1];
                  neg_r_in = below[W-1];
                  count_in = 5'(W - 1);
                  err_in = (top == '0);
                  state_in = (top == '0) ? S_DONE : S_DIV;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MULT: begin
            wide_in = prod_ff;
            state_in = S_DONE;
         end
         S_DIV: begin
            trial = {rem_ff[W-1:0], quot_ff[W-1]} - {1'b0, dvs_ff};
            if (trial[W]) begin
               rem_in = {rem_ff[W-1:0], quot_ff[W-1]};
               quot_in = {quot_ff[W-2:0], 1'b0};
            end else begin
               rem_in = trial;
               quot_in = {quot_ff[W-2:0], 1'b1};
            end
            count_in = count_ff - 5'd1;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (op_ff == scm_pkg::OP_DIV && !err_ff) begin
               wide_in = neg_q_ff ? -(2*W)'(quot_ff) : (2*W)'(quot_ff);
            end else if (op_ff == scm_pkg::OP_MOD && !err_ff) begin
               wide_in = neg_r_ff ? -(2*W)'(rem_ff[W-1:0]) : (2*W)'(rem_ff[W-1:0]);
            end
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         err_ff <= (state_ff == S_DONE) ? 1'b0 : err_in;
      end
      op_ff <= op_in;
      count_ff <= count_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      prod_ff <= prod_in;
      wide_ff <= wide_in;
   end

   // The zero-divisor flag is captured alongside the result in the final step.
   logic zero_div_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         zero_div_ff <= err_ff;
      end
   end

   assign status.done = done_ff;
   assign status.error = zero_div_ff || wide_ff > (2*W)'(scm_pkg::MagLimit)
                         || wide_ff < -(2*W)'(scm_pkg::MagLimit);
   assign result = W'(wide_ff);
endmodule

/* src/stack_calculator_machine.sv */
// Top level: instruction sequencer, stack memory and shared arithmetic unit.
// Start, push, pop and ignored beats complete in the idle state; dup, swap and the
// arithmetic instructions read the stack and write back, division running 31 divider
// steps unless the divisor is zero, and an out-of-range result skips the write-back.
// Finish raises rsp_valid after the stack read, later while the previous result
// waits. Reset empties the stack and clears the error latch.
`timescale 1ns / 1ps
module stack_calculator_machine #(
   parameter int unsigned STACK_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_kind,
   input  logic signed [30:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [30:0] rsp_value,
   output logic        rsp_is_error
);
   localparam int unsigned W = scm_pkg::ValueWidth;
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_TOP, S_WAIT_TOP, S_RD_BELOW, S_WAIT_BELOW,
      S_SWAP_WR, S_ALU_GO, S_ALU_WAIT, S_WRITE, S_FIN_WAIT, S_FIN_OUT
   } state_type;

   state_type state_ff;
   scm_pkg::kind_type kind_ff;
   logic [DW-1:0] depth_ff;
   logic err_ff;
   logic signed [W-1:0] top_ff, below_ff;
   logic rsp_valid_ff, rsp_err_ff;
   logic signed [W-1:0] rsp_value_ff;

   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [W-1:0] ram_wdata, ram_rdata;
   scm_pkg::alu_ctrl_type alu_ctrl;
   scm_pkg::alu_status_type alu_status;
   logic signed [W-1:0] alu_result;
   logic accept;

   scm_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   scm_alu u_alu (
      .clock(clock), .reset(reset), .ctrl(alu_ctrl), .below(below_ff),
      .top(top_ff), .status(alu_status), .result(alu_result)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_is_error = rsp_err_ff;

   always_comb begin
      ram_we = 1'b0;
      ram_addr = '0;
      ram_wdata = W'(req_operand);
      alu_ctrl.start = (state_ff == S_ALU_GO);
      case (kind_ff)
         scm_pkg::KIND_ADD: alu_ctrl.op = scm_pkg::OP_ADD;
         scm_pkg::KIND_SUB: alu_ctrl.op = scm_pkg::OP_SUB;
         scm_pkg::KIND_MUL: alu_ctrl.op = scm_pkg::OP_MUL;
         scm_pkg::KIND_DIV: alu_ctrl.op = scm_pkg::OP_DIV;
         scm_pkg::KIND_MOD: alu_ctrl.op = scm_pkg::OP_MOD;
         default: alu_ctrl.op = scm_pkg::OP_NEG;
      endcase
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == scm_pkg::KIND_START) begin
                  ram_we = 1'b1;
               end else if (req_kind == scm_pkg::KIND_PUSH && !err_ff
                            && depth_ff < DW'(STACK_DEPTH)) begin
                  ram_we = 1'b1;
                  ram_addr = AW'(depth_ff);
               end else if (req_kind == scm_pkg::KIND_FINISH) begin
                  ram_addr = '0;
               end
            end
         end
         S_RD_TOP: ram_addr = AW'(depth_ff - DW'(1));
         S_RD_BELOW: ram_addr = AW'(depth_ff - DW'(2));
         S_SWAP_WR: begin
            ram_we = 1'b1;
            ram_addr = AW'(depth_ff - DW'(2));
            ram_wdata = top_ff;
         end
         S_WRITE: begin
            ram_we = 1'b1;
            if (kind_ff == scm_pkg::KIND_DUP) begin
               ram_addr = AW'(depth_ff);
               ram_wdata = top_ff;
            end else if (kind_ff == scm_pkg::KIND_SWAP) begin
               ram_addr = AW'(depth_ff - DW'(1));
               ram_wdata = below_ff;
            end else if (kind_ff == scm_pkg::KIND_NEGATE) begin
               ram_addr = AW'(depth_ff - DW'(1));
               ram_wdata = alu_result;
            end else begin
               ram_addr = AW'(depth_ff - DW'(2));
               ram_wdata = alu_result;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
         err_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_FIN_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff <= scm_pkg::kind_type'(req_kind);
                  if (req_kind == scm_pkg::KIND_START) begin
                     depth_ff <= DW'(1);
                     err_ff <= 1'b0;
                  end else if (req_kind == scm_pkg::KIND_FINISH) begin
                     state_ff <= S_FIN_WAIT;
                  end else if (req_kind > scm_pkg::KIND_FINISH || err_ff) begin
                     state_ff <= S_IDLE;
                  end else if (req_kind == scm_pkg::KIND_PUSH) begin
                     if (depth_ff < DW'(STACK_DEPTH)) depth_ff <= depth_ff + DW'(1);
                     else err_ff <= 1'b1;
                  end else if (depth_ff == '0) begin
                     err_ff <= 1'b1;
                  end else if (req_kind == scm_pkg::KIND_POP) begin
                     depth_ff <= depth_ff - DW'(1);
                  end else if (req_kind >= scm_pkg::KIND_SWAP && depth_ff < DW'(2)) begin
                     err_ff <= 1'b1;
                  end else if (req_kind == scm_pkg::KIND_DUP
                               && depth_ff >= DW'(STACK_DEPTH)) begin
                     err_ff <= 1'b1;
                  end else begin
                     state_ff <= S_RD_TOP;
                  end
               end
            end
            S_RD_TOP: state_ff <= S_WAIT_TOP;
            S_WAIT_TOP: begin
               top_ff <= ram_rdata;
               if (kind_ff == scm_pkg::KIND_DUP) state_ff <= S_WRITE;
               else if (kind_ff == scm_pkg::KIND_NEGATE) state_ff <= S_ALU_GO;
               else state_ff <= S_RD_BELOW;
            end
            S_RD_BELOW: state_ff <= S_WAIT_BELOW;
            S_WAIT_BELOW: begin
               below_ff <= ram_rdata;
               state_ff <= (kind_ff == scm_pkg::KIND_SWAP) ? S_SWAP_WR : S_ALU_GO;
            end
            S_SWAP_WR: state_ff <= S_WRITE;
            S_ALU_GO: state_ff <= S_ALU_WAIT;
            S_ALU_WAIT: begin
               if (alu_status.done) begin
                  if (alu_status.error) begin
                     err_ff <= 1'b1;
                     if (kind_ff != scm_pkg::KIND_NEGATE) depth_ff <= depth_ff - DW'(2);
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_WRITE;
                  end
               end
            end
            S_WRITE: begin
               if (kind_ff == scm_pkg::KIND_DUP) depth_ff <= depth_ff + DW'(1);
               else if (kind_ff != scm_pkg::KIND_NEGATE && kind_ff != scm_pkg::KIND_SWAP)
                  depth_ff <= depth_ff - DW'(1);
               state_ff <= S_IDLE;
            end
            S_FIN_WAIT: state_ff <= S_FIN_OUT;
            S_FIN_OUT: begin
               // The new beat is loaded once the output register is free or being taken.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  if (err_ff || depth_ff != DW'(1)) begin
                     rsp_err_ff <= 1'b1;
                     rsp_value_ff <= '0;
                  end else begin
                     rsp_err_ff <= 1'b0;
                     rsp_value_ff <= ram_rdata;
                  end
                  depth_ff <= '0;
                  err_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* tb/scm_checker.sv */
// Checker for the stack calculator: predicts finish results and compares them beat by beat.
`timescale 1ns / 1ps
module scm_checker #(
   parameter int unsigned DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [3:0]         req_kind,
   input  logic signed [30:0] req_operand,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [30:0] rsp_value,
   input  logic               rsp_is_error,
   output int                 fail_count,
   output int                 pending
);
   typedef struct {
      logic signed [30:0] value;
      logic               is_error;
   } finish_result_type;

   longint            calc_stack [DEPTH];
   int unsigned       calc_depth;
   bit                calc_fault;
   finish_result_type finish_queue [$];

   assign pending = finish_queue.size();

   function automatic bit bool_out_of_range(longint r);
      return r > longint'(scm_pkg::MagLimit) || r < -longint'(scm_pkg::MagLimit);
   endfunction

   task automatic calc_push(longint v);
      if (calc_depth >= DEPTH) calc_fault = 1'b1;
      else begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end
   endtask

   // Applies one instruction to the predicted machine state.
   task automatic calc_execute(logic [3:0] kind, logic signed [30:0] operand);
      longint top, below, r;
      finish_result_type res;
      if (kind == scm_pkg::KIND_START) begin
         calc_depth = 0;
         calc_fault = 1'b0;
         calc_push(longint'(operand));
      end else if (kind == scm_pkg::KIND_FINISH) begin
         if (calc_fault || calc_depth != 1) begin
            res.value = '0;
            res.is_error = 1'b1;
         end else begin
            res.value = calc_stack[0][30:0];
            res.is_error = 1'b0;
         end
         finish_queue = {finish_queue, res};
         calc_depth = 0;
         calc_fault = 1'b0;
      end else if (kind > scm_pkg::KIND_FINISH || calc_fault) begin
         // Unused kinds and anything after a fault change nothing.
      end else if (kind == scm_pkg::KIND_PUSH) begin
         calc_push(longint'(operand));
      end else if (calc_depth < 1) begin
         calc_fault = 1'b1;
      end else if (kind == scm_pkg::KIND_POP) begin
         calc_depth--;
      end else if (kind == scm_pkg::KIND_NEGATE) begin
         r = -calc_stack[calc_depth-1];
         if (bool_out_of_range(r)) calc_fault = 1'b1;
         else calc_stack[calc_depth-1] = r;
      end else if (kind == scm_pkg::KIND_DUP) begin
         calc_push(calc_stack[calc_depth-1]);
      end else if (calc_depth < 2) begin
         calc_fault = 1'b1;
      end else begin
         top = calc_stack[calc_depth-1];
         below = calc_stack[calc_depth-2];
         if (kind == scm_pkg::KIND_SWAP) begin
            calc_stack[calc_depth-1] = below;
            calc_stack[calc_depth-2] = top;
         end else begin
            calc_depth -= 2;
            r = 0;
            case (kind)
               scm_pkg::KIND_ADD: r = below + top;
               scm_pkg::KIND_SUB: r = below - top;
               scm_pkg::KIND_MUL: r = below * top;
               default: begin
                  if (top == 0) calc_fault = 1'b1;
                  else if (kind == scm_pkg::KIND_DIV) r = below / top;
                  else r = below % top;
               end
            endcase
            if (!calc_fault) begin
               if (bool_out_of_range(r)) calc_fault = 1'b1;
               else calc_push(r);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      finish_result_type exp_res;
      if (reset) begin
         calc_depth = 0;
         calc_fault = 1'b0;
      end else begin
         if (req_valid && req_ready) calc_execute(req_kind, req_operand);
         if (rsp_valid && rsp_ready) begin
            if (finish_queue.size() == 0) begin
               $error("unexpected result beat: value %0d is_error %0b", rsp_value, rsp_is_error);
               fail_count++;
            end else begin
               exp_res = finish_queue.pop_front();
               if (rsp_value !== exp_res.value) begin
                  $error("value: expected %0d, actual %0d", exp_res.value, rsp_value);
                  fail_count++;
               end
               if (rsp_is_error !== exp_res.is_error) begin
                  $error("is_error: expected %0b, actual %0b", exp_res.is_error, rsp_is_error);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

/* tb/stack_calculator_machine_tb.sv */
// Testbench top: drives instruction beats, stalls the result side and gives the verdict.
`timescale 1ns / 1ps
module stack_calculator_machine_tb;
   localparam int unsigned Depth = 8;
   localparam logic [3:0] KindUnusedLo = 4'd12;
   localparam logic [3:0] KindUnusedHi = 4'd15;
   localparam int WatchdogLimit = 20000;
   localparam int RandomItems = 800;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_kind;
   logic signed [30:0] req_operand;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [30:0] rsp_value;
   logic               rsp_is_error;
   int                 fail_count;
   int                 pending;
   bit                 quiet;
   int                 stall_cycles;
   int                 sent;

   stack_calculator_machine #(.STACK_DEPTH(Depth)) u_top (.*);

   scm_checker #(.DEPTH(Depth)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (quiet) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 31);
   end

   // Cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_beat(logic [3:0] kind, logic signed [30:0] operand);
      if (!quiet && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_kind <= kind;
      req_operand <= operand;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   function automatic logic signed [30:0] pick_operand();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 65) return 31'(int'($urandom_range(2000)) - 1000);
      if (sel < 80) return 31'(longint'($urandom_range(2000000000)) - 1000000000);
      if (sel < 88) return $urandom_range(1) ? 31'sd1000000000 : -31'sd1000000000;
      if (sel < 92) return $urandom_range(1) ? 31'sd0 : 31'sd1;
      return 31'($urandom);
   endfunction

   function automatic logic [3:0] pick_unused_kind();
      return 4'($urandom_range(KindUnusedLo, KindUnusedHi));
   endfunction

   task automatic run_directed();
      send_beat(scm_pkg::KIND_START, 31'sd1000000000);
      send_beat(scm_pkg::KIND_FINISH, 31'sd0);
      send_beat(scm_pkg::KIND_START, -31'sd1000000000);
      send_beat(scm_pkg::KIND_NEGATE, 31'sd0);
      send_beat(scm_pkg::KIND_FINISH, 31'sd0);
      // An operand beyond the bound is stored, but negating it faults.
      send_beat(scm_pkg::KIND_START, {1'b1, 30'd0});
      send_beat(scm_pkg::KIND_NEGATE, 31'sd0);
      send_beat(scm_pkg::KIND_FINISH, 31'sd0);
      send_beat(scm_pkg::KIND_START, 31'sd7);
      send_beat(scm_pkg::KIND_PUSH, -31'sd2);
      send_beat(scm_pkg::KIND_SWAP, 31'sd0);
      send_beat(scm_pkg::KIND_MOD, 31'sd0);
      send_beat(scm_pkg::KIND_PUSH, 31'sd0);
      send_beat(scm_pkg::KIND_DIV, 31'sd0);
      send_beat(scm_pkg::KIND_FINISH, 31'sd0);
      // Instructions after a finish act on the empty stack.
      send_beat(scm_pkg::KIND_POP, 31'sd0);
      send_beat(scm_pkg::KIND_PUSH, 31'sd5);
      send_beat(scm_pkg::KIND_FINISH, 31'sd0);
      send_beat(scm_pkg::KIND_START, -31'sd1);
      for (int i = 0; i < Depth; i++) send_beat(scm_pkg::KIND_DUP, 31'sd0);
      send_beat(scm_pkg::KIND_FINISH, 31'sd0);
      send_beat(pick_unused_kind(), 31'h7fffffff);
      send_beat(scm_pkg::KIND_FINISH, 31'sd0);
   endtask

   // Random programs that open with a start and mostly end with a finish, plus some noise beats.
   task automatic run_random();
      int unsigned depth_guess, n_ops, sel;
      logic [3:0] kind;
      while (sent < RandomItems) begin
         quiet = (sent > 350 && sent < 500);
         if ($urandom_range(99) < 10) begin
            send_beat(4'($urandom_range(15)), pick_operand());
         end else begin
            send_beat(scm_pkg::KIND_START, pick_operand());
            depth_guess = 1;
            n_ops = $urandom_range(1, 10);
            for (int i = 0; i < n_ops; i++) begin
               sel = $urandom_range(99);
               if (depth_guess < 2 && sel < 60) kind = scm_pkg::KIND_PUSH;
               else if (sel < 15) kind = scm_pkg::KIND_PUSH;
               else if (sel < 20) kind = scm_pkg::KIND_DUP;
               else kind = 4'($urandom_range(scm_pkg::KIND_POP, scm_pkg::KIND_MOD));
               send_beat(kind, pick_operand());
               case (kind)
                  scm_pkg::KIND_PUSH, scm_pkg::KIND_DUP: depth_guess++;
                  scm_pkg::KIND_POP: if (depth_guess > 0) depth_guess--;
                  scm_pkg::KIND_ADD, scm_pkg::KIND_SUB, scm_pkg::KIND_MUL,
                  scm_pkg::KIND_DIV, scm_pkg::KIND_MOD:
                     if (depth_guess > 1) depth_guess--;
                  default: ;
               endcase
            end
            if ($urandom_range(99) < 95) send_beat(scm_pkg::KIND_FINISH, pick_operand());
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = scm_pkg::KIND_START;
      req_operand = '0;
      quiet = 1'b0;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

/* files.f */
src/scm_pkg.sv
src/scm_ram.sv
src/scm_alu.sv
src/stack_calculator_machine.sv
tb/scm_checker.sv
tb/stack_calculator_machine_tb.sv
